>>> design/cau_pkg.sv
// Package holding the transaction types and operation codes of the complex arithmetic unit.
package cau_pkg;

	typedef enum logic [2:0] {
		CMD_ADD = 3'd0,
		CMD_SUB = 3'd1,
		CMD_MUL = 3'd2,
		CMD_DIV = 3'd3,
		CMD_EQ  = 3'd4,
		CMD_NE  = 3'd5
	} cmd_t;

	typedef struct packed {
		logic [2:0]         command;
		logic signed [31:0] a_re;
		logic signed [31:0] a_im;
		logic signed [31:0] b_re;
		logic signed [31:0] b_im;
	} in_item_t;

	typedef struct packed {
		logic signed [31:0] res_re;
		logic signed [31:0] res_im;
		logic               compare_true;
		logic               overflow;
		logic               divide_by_zero;
	} out_item_t;

endpackage

>>> design/cau_front.sv
// Front end: accepts transactions, narrows their operands and queues them.
module cau_front #(
	parameter int WORD_BITS = 32,
	parameter int DEPTH_LOG = 2
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  cau_pkg::in_item_t in_item,
	output logic              q_valid,
	input  logic              q_ready,
	output cau_pkg::in_item_t q_item
);
	import cau_pkg::*;

	localparam int DEPTH = 1 << DEPTH_LOG;

	in_item_t               mem_q [DEPTH];
	logic [DEPTH_LOG-1:0]   wr_q, rd_q;
	logic [DEPTH_LOG:0]     cnt_q;
	in_item_t               norm;
	logic                   push, pop;

	// Operands narrowed to the word and sign-extended; unused codes are passed on.
	always_comb begin
		norm = in_item;
		norm.a_re = 32'(signed'(in_item.a_re[WORD_BITS-1:0]));
		norm.a_im = 32'(signed'(in_item.a_im[WORD_BITS-1:0]));
		norm.b_re = 32'(signed'(in_item.b_re[WORD_BITS-1:0]));
		norm.b_im = 32'(signed'(in_item.b_im[WORD_BITS-1:0]));
	end

	assign in_ready = (cnt_q != (DEPTH_LOG+1)'(DEPTH));
	assign q_valid  = (cnt_q != '0);
	assign push     = in_valid && in_ready;
	assign pop      = q_valid && q_ready;
	assign q_item   = mem_q[rd_q];

	// Queue storage.
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= norm;
		end
	end

	// Queue pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wr_q <= wr_q + 1'b1;
			if (pop)  rd_q <= rd_q + 1'b1;
			cnt_q <= cnt_q + (DEPTH_LOG+1)'(push) - (DEPTH_LOG+1)'(pop);
		end
	end

endmodule

>>> design/cau_back.sv
// Back end: pipelined add, subtract, multiply, compare and radix-2 divide with saturation.
module cau_back #(
	parameter int FRAC_BITS = 16,
	parameter int WORD_BITS = 32
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               q_valid,
	output logic               q_ready,
	input  cau_pkg::in_item_t  q_item,
	output logic               out_valid,
	input  logic               out_ready,
	output cau_pkg::out_item_t out_item
);
	import cau_pkg::*;

	// Quotient steps: integer part up to 66 bits, then fraction bits.
	localparam int NW    = 66;
	localparam int STEPS = NW + FRAC_BITS;
	localparam int QW    = NW + FRAC_BITS;
	localparam int LAT   = STEPS + 3;
	localparam logic [65:0] POS_LIM = (66'd1 << (WORD_BITS-1)) - 66'd1;
	localparam logic [65:0] NEG_LIM = 66'd1 << (WORD_BITS-1);

	// Pipeline control: whole pipe advances when the output side can take data.
	logic adv;
	logic [LAT-1:0] vld_q;
	logic out_full_q;
	assign adv      = !out_full_q || out_ready || !vld_q[LAT-1];
	assign q_ready  = adv;

	// Stage 1: products, sums, differences and operand equality.
	logic [2:0] cmd_s1;
	logic signed [63:0] ac_s1, bd_s1, ad_s1, bc_s1, cc_s1, dd_s1;
	logic signed [32:0] sre_s1, sim_s1, dre_s1, dim_s1;
	logic eq_s1;
	always_ff @(posedge clk) begin
		if (adv) begin
			cmd_s1 <= q_item.command;
			ac_s1  <= q_item.a_re * q_item.b_re;
			bd_s1  <= q_item.a_im * q_item.b_im;
			ad_s1  <= q_item.a_re * q_item.b_im;
			bc_s1  <= q_item.a_im * q_item.b_re;
			cc_s1  <= q_item.b_re * q_item.b_re;
			dd_s1  <= q_item.b_im * q_item.b_im;
			sre_s1 <= 33'(q_item.a_re) + 33'(q_item.b_re);
			sim_s1 <= 33'(q_item.a_im) + 33'(q_item.b_im);
			dre_s1 <= 33'(q_item.a_re) - 33'(q_item.b_re);
			dim_s1 <= 33'(q_item.a_im) - 33'(q_item.b_im);
			eq_s1  <= (q_item.a_re == q_item.b_re) && (q_item.a_im == q_item.b_im);
		end
	end

	// Stage 2: sums of products as sign and magnitude, divisor.
	// Commands that do not divide pass through the divider with a divisor of one.
	logic [2:0] cmd_s2;
	logic neg_re_s2, neg_im_s2, eq_s2, dbz_s2;
	logic [65:0] mag_re_s2, mag_im_s2, den_s2;
	logic signed [65:0] xre, xim;
	always_comb begin
		case (cmd_s1)
			CMD_ADD: begin xre = 66'(sre_s1); xim = 66'(sim_s1); end
			CMD_SUB: begin xre = 66'(dre_s1); xim = 66'(dim_s1); end
			CMD_MUL: begin xre = 66'(ac_s1) - 66'(bd_s1); xim = 66'(ad_s1) + 66'(bc_s1); end
			CMD_DIV: begin xre = 66'(ac_s1) + 66'(bd_s1); xim = 66'(bc_s1) - 66'(ad_s1); end
			default: begin xre = '0; xim = '0; end
		endcase
	end
	always_ff @(posedge clk) begin
		if (adv) begin
			cmd_s2    <= cmd_s1;
			eq_s2     <= eq_s1;
			neg_re_s2 <= xre[65];
			neg_im_s2 <= xim[65];
			mag_re_s2 <= xre[65] ? 66'(-xre) : 66'(xre);
			mag_im_s2 <= xim[65] ? 66'(-xim) : 66'(xim);
			den_s2    <= (cmd_s1 == CMD_DIV) ? 66'(cc_s1) + 66'(dd_s1) : 66'd1;
			dbz_s2    <= (cc_s1 == 64'sd0) && (dd_s1 == 64'sd0);
		end
	end

	// Divider stages: one restoring step per stage for both parts.
	logic [2:0]    cmd_p [STEPS+1];
	logic          eq_p [STEPS+1], dbz_p [STEPS+1], nre_p [STEPS+1], nim_p [STEPS+1];
	logic [65:0]   den_p [STEPS+1];
	logic [QW-1:0] nre_p_v [STEPS+1], nim_p_v [STEPS+1];
	logic [QW-1:0] qre_p [STEPS+1], qim_p [STEPS+1];
	logic [66:0]   rre_p [STEPS+1], rim_p [STEPS+1];

	assign cmd_p[0]   = cmd_s2;
	assign eq_p[0]    = eq_s2;
	assign dbz_p[0]   = dbz_s2;
	assign nre_p[0]   = neg_re_s2;
	assign nim_p[0]   = neg_im_s2;
	assign den_p[0]   = den_s2;
	assign nre_p_v[0] = {mag_re_s2, {FRAC_BITS{1'b0}}};
	assign nim_p_v[0] = {mag_im_s2, {FRAC_BITS{1'b0}}};
	assign qre_p[0]   = '0;
	assign qim_p[0]   = '0;
	assign rre_p[0]   = '0;
	assign rim_p[0]   = '0;

	for (genvar i = 0; i < STEPS; i++) begin : g_div
		logic [66:0] tre, tim;
		assign tre = {rre_p[i][65:0], nre_p_v[i][QW-1]};
		assign tim = {rim_p[i][65:0], nim_p_v[i][QW-1]};
		always_ff @(posedge clk) begin
			if (adv) begin
				cmd_p[i+1]   <= cmd_p[i];
				eq_p[i+1]    <= eq_p[i];
				dbz_p[i+1]   <= dbz_p[i];
				nre_p[i+1]   <= nre_p[i];
				nim_p[i+1]   <= nim_p[i];
				den_p[i+1]   <= den_p[i];
				nre_p_v[i+1] <= nre_p_v[i] << 1;
				nim_p_v[i+1] <= nim_p_v[i] << 1;
				qre_p[i+1]   <= {qre_p[i][QW-2:0], tre >= {1'b0, den_p[i]}};
				qim_p[i+1]   <= {qim_p[i][QW-2:0], tim >= {1'b0, den_p[i]}};
				rre_p[i+1]   <= (tre >= {1'b0, den_p[i]}) ? tre - {1'b0, den_p[i]} : tre;
				rim_p[i+1]   <= (tim >= {1'b0, den_p[i]}) ? tim - {1'b0, den_p[i]} : tim;
			end
		end
	end

	// Final stage: choose magnitude, saturate, form the result.
	logic [QW-1:0] mre, mim;
	logic          ore, oim;
	logic [65:0]   wre, wim;
	out_item_t     res;
	always_comb begin
		case (cmd_p[STEPS])
			CMD_MUL: begin
				mre = qre_p[STEPS] >> (FRAC_BITS + FRAC_BITS);
				mim = qim_p[STEPS] >> (FRAC_BITS + FRAC_BITS);
			end
			CMD_DIV: begin mre = qre_p[STEPS]; mim = qim_p[STEPS]; end
			default: begin
				mre = qre_p[STEPS] >> FRAC_BITS;
				mim = qim_p[STEPS] >> FRAC_BITS;
			end
		endcase
		if (nre_p[STEPS]) begin
			ore = (mre > QW'(NEG_LIM));
			wre = ore ? -NEG_LIM : -mre[65:0];
		end else begin
			ore = (mre > QW'(POS_LIM));
			wre = ore ? POS_LIM : mre[65:0];
		end
		if (nim_p[STEPS]) begin
			oim = (mim > QW'(NEG_LIM));
			wim = oim ? -NEG_LIM : -mim[65:0];
		end else begin
			oim = (mim > QW'(POS_LIM));
			wim = oim ? POS_LIM : mim[65:0];
		end
		res = '0;
		case (cmd_p[STEPS])
			CMD_ADD, CMD_SUB, CMD_MUL: begin
				res.res_re   = wre[31:0];
				res.res_im   = wim[31:0];
				res.overflow = ore || oim;
			end
			CMD_DIV: begin
				if (dbz_p[STEPS]) begin
					res.divide_by_zero = 1'b1;
				end else begin
					res.res_re   = wre[31:0];
					res.res_im   = wim[31:0];
					res.overflow = ore || oim;
				end
			end
			CMD_EQ:  res.compare_true = eq_p[STEPS];
			CMD_NE:  res.compare_true = !eq_p[STEPS];
			default: res = '0;
		endcase
	end

	// Valid tracking through the pipe.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (adv) begin
			vld_q <= {vld_q[LAT-2:0], q_valid};
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_full_q <= 1'b0;
		end else if (adv) begin
			out_full_q <= vld_q[LAT-2];
		end else if (out_ready) begin
			out_full_q <= 1'b0;
		end
	end
	always_ff @(posedge clk) begin
		if (adv) begin
			out_item <= res;
		end
	end
	assign out_valid = out_full_q;

endmodule

>>> design/complex_arith_unit.sv
// Complex arithmetic unit: one add, sub, mul, div or compare per transaction.
// Throughput: one transaction per cycle while the output is not stalled; a four-entry queue decouples front and back.
// Every result passes through the divider pipe, which resolves one quotient bit per stage.
// Every command takes the same path, so results leave in order.
// Reset (arst_n low) empties the queue and the pipeline; no data is held over.
module complex_arith_unit #(
	parameter int FRAC_BITS = 16,
	parameter int WORD_BITS = 32
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  cau_pkg::in_item_t  in_item,
	output logic               out_valid,
	input  logic               out_ready,
	output cau_pkg::out_item_t out_item
);
	import cau_pkg::*;

	logic     q_valid, q_ready;
	in_item_t q_item;

	cau_front #(.WORD_BITS(WORD_BITS), .DEPTH_LOG(2)) u_front (
		.clk, .arst_n, .in_valid, .in_ready, .in_item,
		.q_valid, .q_ready, .q_item
	);

	cau_back #(.FRAC_BITS(FRAC_BITS), .WORD_BITS(WORD_BITS)) u_back (
		.clk, .arst_n, .q_valid, .q_ready, .q_item,
		.out_valid, .out_ready, .out_item
	);

endmodule
